// ===== rtl/flmc_pkg.sv =====
// shared types and constants for the monotonic counter log
// no dependencies
package flmc_pkg;

    localparam int SLOT_COUNT  = 1024;
    localparam int VALUE_WIDTH = 64;
    localparam int FIELD_W     = 64;
    localparam int ADDR_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [ADDR_W-1:0]      addr_t;
    typedef logic [ADDR_W:0]        fill_t;
    typedef logic [FIELD_W-1:0]     field_t;

    localparam value_t VALUE_MASK = '1;
    localparam addr_t  LAST_SLOT  = addr_t'(SLOT_COUNT - 1);
    localparam addr_t  FIRST_SLOT = '0;

    typedef struct packed {
        addr_t  rd_addr;
        logic   wr_en;
        addr_t  wr_addr;
        value_t wr_data;
    } store_req_t;

    typedef struct packed {
        logic   valid;
        value_t value;
        logic   erased;
    } result_t;

endpackage

// ===== rtl/flash_log_monotonic_counter_unit.sv =====
// an item reads the pointer slot, scans on to the first erased slot, reads the slot
// before it and writes the new count; no new item is taken until that write (in_stall);
// the scan looks at one slot per cycle through the single store read port
// reset: search pointer to slot zero, fill count to zero so every slot reads erased,
// no clearing pass; output register empty
module flash_log_monotonic_counter_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             func,
    input  flmc_pkg::field_t forced_value,
    output logic             out_valid,
    input  logic             out_stall,
    output flmc_pkg::field_t counter_value,
    output logic             store_erased
);
    import flmc_pkg::*;

    store_req_t req;
    value_t     rd_data;
    result_t    res;
    logic       out_free;
    logic       out_valid_reg;
    logic       out_valid_next;
    field_t     counter_value_reg;
    logic       store_erased_reg;

    flmc_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_data (rd_data)
    );

    flmc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .forced_value (forced_value),
        .out_free     (out_free),
        .rd_data      (rd_data),
        .req          (req),
        .res          (res)
    );

    // output item register
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            counter_value_reg <= field_t'(res.value);
            store_erased_reg  <= res.erased;
        end
    end

    assign out_valid     = out_valid_reg;
    assign counter_value = counter_value_reg;
    assign store_erased  = store_erased_reg;

endmodule

// ===== rtl/flmc_store.sv =====
// slot store: one write port, one registered read port, fill count for erase
// depends on flmc_pkg
module flmc_store (
    input  logic                clk,
    input  logic                rst_n,
    input  flmc_pkg::store_req_t req,
    output flmc_pkg::value_t    rd_data
);
    import flmc_pkg::*;

    value_t mem [SLOT_COUNT];
    value_t rd_raw_reg;
    fill_t  fill_reg;
    fill_t  fill_next;
    logic   rd_valid_reg;
    logic   rd_valid_next;

    // slots are written in order, so everything at or past the fill count is erased
    assign fill_next     = fill_t'(req.wr_addr) + fill_t'(1);
    assign rd_valid_next = fill_t'(req.rd_addr) < fill_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_raw_reg <= mem[req.rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                fill_reg <= fill_next;
            end
            rd_valid_reg <= rd_valid_next;
        end
    end

    assign rd_data = rd_valid_reg ? rd_raw_reg : VALUE_MASK;

endmodule

// ===== rtl/flmc_ctrl.sv =====
// sequencer: scans for the first erased slot, reads the previous slot,
// computes the new count and writes it back; depends on flmc_pkg
module flmc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 func,
    input  flmc_pkg::field_t     forced_value,
    input  logic                 out_free,
    input  flmc_pkg::value_t     rd_data,
    output flmc_pkg::store_req_t req,
    output flmc_pkg::result_t    res
);
    import flmc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CHECK = 3'b010,
        S_CALC  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    addr_t  ptr_reg;
    addr_t  scan_reg;
    addr_t  next_reg;
    addr_t  prev_reg;
    logic   func_reg;
    value_t forced_reg;

    logic   slot_erased;
    logic   scan_more;
    addr_t  found;
    addr_t  found_prev;
    logic   use_forced;
    value_t inc_value;
    value_t pick_value;
    value_t new_value;
    logic   done;

    always_comb
    begin
        slot_erased = (rd_data == VALUE_MASK);
        scan_more   = !slot_erased && (scan_reg != LAST_SLOT);
        found       = slot_erased ? scan_reg : FIRST_SLOT;
        found_prev  = (found == FIRST_SLOT) ? LAST_SLOT : found - addr_t'(1);
    end

    always_comb
    begin
        use_forced = func_reg && (forced_reg != '0) && (forced_reg != VALUE_MASK);
        inc_value  = rd_data + value_t'(1);
        pick_value = use_forced ? forced_reg : inc_value;
        new_value  = (pick_value == VALUE_MASK) ? '0 : pick_value;
    end

    assign done     = (state_reg == S_CALC) && out_free;
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        req.wr_en   = done;
        req.wr_addr = next_reg;
        req.wr_data = new_value;
        case (state_reg)
            S_IDLE:  req.rd_addr = ptr_reg;
            S_CHECK: req.rd_addr = scan_more ? scan_reg + addr_t'(1) : found_prev;
            S_CALC:  req.rd_addr = prev_reg;
            default: req.rd_addr = ptr_reg;
        endcase
        res.valid  = done;
        res.value  = new_value;
        res.erased = (next_reg == FIRST_SLOT);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!scan_more)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ptr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (done)
            begin
                ptr_reg <= next_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_reg   <= func;
                    forced_reg <= forced_value[VALUE_WIDTH-1:0];
                    scan_reg   <= ptr_reg;
                end
            end
            S_CHECK:
            begin
                if (scan_more)
                begin
                    scan_reg <= scan_reg + addr_t'(1);
                end
                else
                begin
                    next_reg <= found;
                    prev_reg <= found_prev;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== rtl/flmc_checker.sv =====
// port-level checks for the monotonic counter log, bound to the top level
// depends on flmc_pkg and flash_log_monotonic_counter_unit
module flmc_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             func,
    input flmc_pkg::field_t forced_value,
    input logic             out_valid,
    input logic             out_stall,
    input flmc_pkg::field_t counter_value,
    input logic             store_erased
);
    import flmc_pkg::*;

    // one item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken again right after an accept");

    // a new result only appears while an item is in work
    a_result_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without an item in work");

    // the stored count never looks like an erased slot
    a_never_erased_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (counter_value[VALUE_WIDTH-1:0] != VALUE_MASK))
        else $error("counter value equals the erased pattern");

    a_upper_bits_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((counter_value >> VALUE_WIDTH) == '0))
        else $error("counter value has bits above the value width");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(counter_value) && $stable(store_erased)))
        else $error("stalled result changed");

endmodule

bind flash_log_monotonic_counter_unit flmc_checker u_flmc_checker (.*);
